// ===== hdl/teq_pkg.sv =====
// ----------------------------------------------------------------------------
// teq_pkg: shared types and constants for the time-ordered event queue
// Event word layout, command codes, status codes and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package teq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned DevW  = 8;
  localparam int unsigned ValW  = 32;
  localparam int unsigned TimeW = 32;
  localparam int unsigned OccW  = 5;

  typedef enum logic [1:0] {
    KIND_INSERT    = 2'd0,
    KIND_REM_FIRST = 2'd1,
    KIND_REM_DEV   = 2'd2
  } teq_kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } teq_status_e;

  typedef struct packed {
    logic [DevW-1:0]         device;
    logic signed [ValW-1:0]  value;
    logic [TimeW-1:0]        etime;
  } teq_word_t;

  // Broadcast to every cell: insert enable and the incoming word
  typedef struct packed {
    logic      ins_en;
    teq_word_t word;
  } teq_ctrl_t;

endpackage : teq_pkg

`default_nettype wire

// ===== hdl/teq_cell.sv =====
// ----------------------------------------------------------------------------
// teq_cell: one slot of the sorted event queue
// Holds one event; on insert takes the new word or its left neighbour's word,
// on removal takes its right neighbour's word.
// ----------------------------------------------------------------------------
`default_nettype none

module teq_cell
  import teq_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire teq_ctrl_t ctrl_i,
  input  wire logic      shift_i,
  input  wire logic      left_gt_i,
  input  wire logic      left_valid_i,
  input  wire teq_word_t left_word_i,
  input  wire logic      right_valid_i,
  input  wire teq_word_t right_word_i,
  output logic           gt_o,
  output logic           match_o,
  output logic           valid_o,
  output teq_word_t      word_o
);

  logic      valid_q, valid_d;
  teq_word_t word_q, word_d;

  // an empty slot counts as later than any event
  assign gt_o    = !valid_q || (word_q.etime > ctrl_i.word.etime);
  assign match_o = valid_q && (word_q.device == ctrl_i.word.device);
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (ctrl_i.ins_en) begin
      if (left_gt_i) begin
        valid_d = left_valid_i;
        word_d  = left_word_i;
      end else if (gt_o) begin
        valid_d = 1'b1;
        word_d  = ctrl_i.word;
      end
    end else if (shift_i) begin
      valid_d = right_valid_i;
      word_d  = right_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule : teq_cell

`default_nettype wire

// ===== hdl/time_ordered_event_queue.sv =====
// ----------------------------------------------------------------------------
// time_ordered_event_queue: bounded event queue sorted by scheduled time
// Row of slot cells; inserts shift later events right, removals shift left.
// ----------------------------------------------------------------------------
//  channel  | ports                                           | handshake
//  command  | kind_i device_id_i event_value_i event_time_i   | start_i & !busy_o
//  result   | status_o head_valid_o head_device_o head_value_o| result_valid_o
//           | head_time_o occupancy_o                         | (one cycle)
//
//  One command per cycle; busy_o stays low. Every cell compares and moves in
//  the same cycle, the earliest-match search is one prefix over the match row.
//  The result word shows on the cycle after acceptance, for that cycle only.
//  Reset empties the queue at once (slot valid bits only).
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`default_nettype none

module time_ordered_event_queue
  import teq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic [DevW-1:0]    device_id_i,
  input  wire logic signed [ValW-1:0] event_value_i,
  input  wire logic [TimeW-1:0]   event_time_i,
  output logic                    result_valid_o,
  output logic [1:0]              status_o,
  output logic                    head_valid_o,
  output logic [DevW-1:0]         head_device_o,
  output logic signed [ValW-1:0]  head_value_o,
  output logic [TimeW-1:0]        head_time_o,
  output logic [OccW-1:0]         occupancy_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  teq_ctrl_t              ctrl;
  logic [QUEUE_DEPTH-1:0] gt, match, valid, shift, seen;
  teq_word_t              words [QUEUE_DEPTH];
  logic                   accept, full, empty, found;
  logic                   rem_first_en, rem_dev_en;
  teq_status_e            status_d, status_q;
  logic                   strobe_q;
  logic [CntW-1:0]        occ_q, occ_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = valid[QUEUE_DEPTH-1];
  assign empty  = !valid[0];
  assign found  = |match;

  // slots at or beyond the earliest matching device
  assign seen = match | ~(match - QUEUE_DEPTH'(1));

  always_comb begin
    ctrl.word.device = device_id_i;
    ctrl.word.value  = event_value_i;
    ctrl.word.etime  = event_time_i;
    ctrl.ins_en      = 1'b0;
    rem_first_en     = 1'b0;
    rem_dev_en       = 1'b0;
    status_d         = ST_OK;
    occ_d            = occ_q;
    case (teq_kind_e'(kind_i))
      KIND_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins_en = accept;
          occ_d       = occ_q + CntW'(1);
        end
      end
      KIND_REM_FIRST: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          rem_first_en = accept;
          occ_d        = occ_q - CntW'(1);
        end
      end
      KIND_REM_DEV: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          rem_dev_en = accept;
          occ_d      = occ_q - CntW'(1);
        end
      end
      default: ;
    endcase
  end

  assign shift = {QUEUE_DEPTH{rem_first_en}} | ({QUEUE_DEPTH{rem_dev_en}} & seen);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic      l_gt, l_valid, r_valid;
    teq_word_t l_word, r_word;
    if (i == 0) begin : g_first
      assign l_gt    = 1'b0;
      assign l_valid = 1'b0;
      assign l_word  = ctrl.word;
    end else begin : g_mid
      assign l_gt    = gt[i-1];
      assign l_valid = valid[i-1];
      assign l_word  = words[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_word  = words[i];
    end else begin : g_inner
      assign r_valid = valid[i+1];
      assign r_word  = words[i+1];
    end
    teq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .shift_i      (shift[i]),
      .left_gt_i    (l_gt),
      .left_valid_i (l_valid),
      .left_word_i  (l_word),
      .right_valid_i(r_valid),
      .right_word_i (r_word),
      .gt_o         (gt[i]),
      .match_o      (match[i]),
      .valid_o      (valid[i]),
      .word_o       (words[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      status_q <= ST_OK;
      occ_q    <= '0;
    end else begin
      strobe_q <= accept;
      if (accept) begin
        status_q <= status_d;
        occ_q    <= occ_d;
      end
    end
  end

  assign result_valid_o = strobe_q;
  assign status_o       = status_q;
  assign head_valid_o   = valid[0];
  assign head_device_o  = valid[0] ? words[0].device : '0;
  assign head_value_o   = valid[0] ? words[0].value  : '0;
  assign head_time_o    = valid[0] ? words[0].etime  : '0;
  assign occupancy_o    = OccW'(occ_q);

  // occupied slots always form a run from slot 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid & (valid + QUEUE_DEPTH'(1))) == '0)
    else $error("queue slots not contiguous");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid) == int'(occ_q))
    else $error("occupancy count out of step with slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> strobe_q)
    else $error("accepted command gave no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && (status_q == ST_FULL) |-> valid[QUEUE_DEPTH-1])
    else $error("full status with free slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.ins_en && !full) |-> !(rem_first_en || rem_dev_en))
    else $error("insert and removal in one cycle");

endmodule : time_ordered_event_queue

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the time-ordered event queue
// Drives insert, removal and unused-kind commands through the start/busy handshake, keeps
// a sorted shadow of the queue and checks every result word against it.
// ----------------------------------------------------------------------------

module tb_top;
  import teq_pkg::*;

  localparam int unsigned Depth      = QueueDepthDefault;
  localparam int unsigned QuietLimit = 200;
  localparam logic [1:0]  KindUnused = 2'd3;

  // Expected result word
  typedef struct {
    logic [1:0]             status;
    logic                   head_valid;
    logic [DevW-1:0]        head_device;
    logic signed [ValW-1:0] head_value;
    logic [TimeW-1:0]       head_time;
    logic [OccW-1:0]        occupancy;
  } queue_view_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   start_i       = 1'b0;
  logic [1:0]             kind_i        = KIND_INSERT;
  logic [DevW-1:0]        device_id_i   = '0;
  logic signed [ValW-1:0] event_value_i = '0;
  logic [TimeW-1:0]       event_time_i  = '0;
  logic                   busy_o;
  logic                   result_valid_o;
  logic [1:0]             status_o;
  logic                   head_valid_o;
  logic [DevW-1:0]        head_device_o;
  logic signed [ValW-1:0] head_value_o;
  logic [TimeW-1:0]       head_time_o;
  logic [OccW-1:0]        occupancy_o;

  // Shadow of the queue, held in time order from slot 0
  teq_word_t   sched_slot [Depth];
  int unsigned sched_count = 0;

  queue_view_t pending_views [$];
  int unsigned fail_cnt     = 0;
  int unsigned quiet_cycles = 0;

  time_ordered_event_queue #(
    .QUEUE_DEPTH(Depth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .device_id_i   (device_id_i),
    .event_value_i (event_value_i),
    .event_time_i  (event_time_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .head_valid_o  (head_valid_o),
    .head_device_o (head_device_o),
    .head_value_o  (head_value_o),
    .head_time_o   (head_time_o),
    .occupancy_o   (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // Shadow queue
  // ------------------------------------------------------------------------
  function automatic void drop_event(int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < sched_count; i++) sched_slot[i] = sched_slot[i+1];
    sched_count--;
  endfunction

  function automatic queue_view_t apply_event_cmd(logic [1:0] kind, logic [DevW-1:0] dev,
                                                  logic signed [ValW-1:0] val,
                                                  logic [TimeW-1:0] tm);
    queue_view_t v;
    int unsigned pos;
    int unsigned i;
    bit          hit;
    v.status = ST_OK;
    case (kind)
      KIND_INSERT: begin
        if (sched_count >= Depth) begin
          v.status = ST_FULL;
        end else begin
          // equal times stay in arrival order
          pos = 0;
          while (pos < sched_count && sched_slot[pos].etime <= tm) pos++;
          for (i = sched_count; i > pos; i--) sched_slot[i] = sched_slot[i-1];
          sched_slot[pos] = '{device: dev, value: val, etime: tm};
          sched_count++;
        end
      end
      KIND_REM_FIRST: begin
        if (sched_count == 0) v.status = ST_EMPTY;
        else drop_event(0);
      end
      KIND_REM_DEV: begin
        if (sched_count == 0) begin
          v.status = ST_EMPTY;
        end else begin
          hit = 1'b0;
          for (i = 0; i < sched_count && !hit; i++) begin
            if (sched_slot[i].device == dev) begin
              drop_event(i);
              hit = 1'b1;
            end
          end
          if (!hit) v.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    v.head_valid  = (sched_count > 0);
    v.head_device = (sched_count > 0) ? sched_slot[0].device : '0;
    v.head_value  = (sched_count > 0) ? sched_slot[0].value  : '0;
    v.head_time   = (sched_count > 0) ? sched_slot[0].etime  : '0;
    v.occupancy   = sched_count[OccW-1:0];
    return v;
  endfunction

  // ------------------------------------------------------------------------
  // Command side
  // ------------------------------------------------------------------------
  task automatic send_cmd(logic [1:0] kind, logic [DevW-1:0] dev,
                          logic [ValW-1:0] val, logic [TimeW-1:0] tm);
    start_i       <= 1'b1;
    kind_i        <= kind;
    device_id_i   <= dev;
    event_value_i <= val;
    event_time_i  <= tm;
    do @(posedge clk_i); while (busy_o);
    pending_views.push_back(apply_event_cmd(kind, dev, val, tm));
  endtask

  task automatic idle_burst();
    start_i <= 1'b0;
    repeat ($urandom_range(1, 8)) @(posedge clk_i);
  endtask

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    queue_view_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_views.size() == 0) begin
        $error("result word with no command outstanding");
        fail_cnt++;
      end else begin
        want = pending_views.pop_front();
        check_field("status",      32'(want.status),      32'(status_o));
        check_field("head_valid",  32'(want.head_valid),  32'(head_valid_o));
        check_field("head_device", 32'(want.head_device), 32'(head_device_o));
        check_field("head_value",  want.head_value,       head_value_o);
        check_field("head_time",   want.head_time,        head_time_o);
        check_field("occupancy",   32'(want.occupancy),   32'(occupancy_o));
      end
    end
  end

  // Ends the run if no word moves on either side for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("time_ordered_event_queue verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_empty_queue();
    send_cmd(KIND_REM_FIRST, 8'h00, 32'h0, 32'h0);
    send_cmd(KIND_REM_DEV,   8'h00, 32'h0, 32'h0);
    send_cmd(KindUnused,     8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Fills to the brim with repeated and extreme times, then one insert too many
  task automatic test_sorted_fill();
    logic [TimeW-1:0] tms [16] = '{32'd100, 32'hFFFF_FFFF, 32'd0, 32'd100,
                                   32'd50, 32'd100, 32'h8000_0000, 32'h7FFF_FFFF,
                                   32'd1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0,
                                   32'd200, 32'd300, 32'd400, 32'd500};
    logic [DevW-1:0]  devs [16] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h55, 8'h01, 8'h02,
                                   8'h03, 8'h80, 8'h7F, 8'h04, 8'h05, 8'h06,
                                   8'h07, 8'h08, 8'h09};
    logic [ValW-1:0]  vals [4]  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    int k;
    for (k = 0; k < 16; k++) send_cmd(KIND_INSERT, devs[k], vals[k % 4] ^ k, tms[k]);
    send_cmd(KIND_INSERT, 8'h3C, 32'h1234_5678, 32'd0);
  endtask

  task automatic test_device_removal();
    send_cmd(KIND_REM_DEV, 8'h3C, 32'h0, 32'h0);
    send_cmd(KIND_REM_DEV, 8'h55, 32'h0, 32'h0);
    send_cmd(KindUnused,   8'h00, 32'h0, 32'h0);
  endtask

  task automatic test_remove_first();
    send_cmd(KIND_REM_FIRST, 8'h00, 32'h0, 32'h0);
    send_cmd(KIND_REM_FIRST, 8'hFF, 32'h0, 32'h0);
  endtask

  // Phases lean towards filling, draining or balance so that the queue keeps
  // passing through both full and empty
  task automatic test_random_traffic(int n, bit allow_gaps);
    int          k;
    int unsigned ins_pct;
    int unsigned r;
    bit          gaps_on;
    logic [1:0]       kind;
    logic [DevW-1:0]  dev;
    logic [ValW-1:0]  val;
    logic [TimeW-1:0] tm;
    ins_pct = 50;
    gaps_on = 1'b0;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       ins_pct = 80;
          1:       ins_pct = 25;
          default: ins_pct = 52;
        endcase
        gaps_on = allow_gaps && ($urandom_range(0, 2) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 2) kind = KindUnused;
      else if (r < ins_pct) kind = KIND_INSERT;
      else if ($urandom_range(0, 1)) kind = KIND_REM_FIRST;
      else kind = KIND_REM_DEV;

      if (kind == KIND_REM_DEV && sched_count > 0 && $urandom_range(0, 2) != 0)
        dev = sched_slot[$urandom_range(0, sched_count - 1)].device;
      else if ($urandom_range(0, 3) == 0)
        dev = DevW'($urandom_range(0, 255));
      else
        dev = DevW'($urandom_range(0, 7));

      case ($urandom_range(0, 9))
        0:       tm = '0;
        1:       tm = '1;
        2, 3, 4, 5: tm = $urandom_range(0, 15);
        default: tm = $urandom;
      endcase

      case ($urandom_range(0, 15))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        default: val = $urandom;
      endcase

      send_cmd(kind, dev, val, tm);
      if (gaps_on && $urandom_range(0, 4) == 0) idle_burst();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_sorted_fill();
    test_device_removal();
    test_remove_first();
    test_random_traffic(1400, 1'b1);
    test_random_traffic(325, 1'b0);

    start_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("time_ordered_event_queue verification clean");
    end else begin
      $display("time_ordered_event_queue verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/teq_pkg.sv
hdl/teq_cell.sv
hdl/time_ordered_event_queue.sv
tb/sv/tb_top.sv
